/* design/bdslp_pkg.sv */
// ----------------------------------------------------------------------------
// bdslp_pkg
// Shared types and constants for the button debouncer with press detection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdslp_pkg;

  // press event codes
  typedef logic [1:0] press_ev_t;
  localparam press_ev_t EV_NONE  = 2'd0;
  localparam press_ev_t EV_SHORT = 2'd1;
  localparam press_ev_t EV_LONG  = 2'd2;

  // item kinds carried in tuser
  localparam logic KIND_POLL   = 1'b0;
  localparam logic KIND_RESYNC = 1'b1;

  // configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_DEBOUNCE_TIME   = 1'd0;
  localparam cfg_idx_t REG_LONG_PRESS_TIME = 1'd1;

  // field widths
  localparam int unsigned NOW_W      = 32;
  localparam int unsigned DEBOUNCE_W = 16;
  localparam int unsigned LONG_W     = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  // configuration reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd30;
  localparam logic [LONG_W-1:0]     LONG_RST     = 32'd1000;

endpackage

`default_nettype wire

/* design/button_debounce_short_long_press.sv */
// ----------------------------------------------------------------------------
// button_debounce_short_long_press
// Debounces polled button samples and reports short and long presses.
// ----------------------------------------------------------------------------
// Path: input transfer to result valid passes the input register, then the
//   result register; state is updated as the item leaves the input reg.
// Throughput: one poll per cycle while the result stream is not stalled; the
//   state update loop (two modular subtracts and compares) limits that rate.
// Reset: rst_n synchronous, active low; clears pipeline valids, button state
//   and loads debounce_time = 30, long_press_time = 1000.
`timescale 1ns / 1ps
`default_nettype none

module button_debounce_short_long_press #(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  // input stream
  input  wire                                    in_tvalid,
  output logic                                   in_tready,
  // tdata: [31:0] now, [32] pressed_level, [39:33] zero
  input  wire  [bdslp_pkg::IN_DATA_W-1:0]        in_tdata,
  // tuser: [0] kind
  input  wire                                    in_tuser,
  // result stream
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  // tdata: [1:0] press_event, [7:2] zero
  output logic [bdslp_pkg::OUT_DATA_W-1:0]       out_tdata,
  // configuration writes
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire  [0:0]                             cfg_index,
  input  wire  [bdslp_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import bdslp_pkg::*;

  // compare width covers both time and the 32-bit long press register
  localparam int unsigned CW = (TIME_BITS > LONG_W) ? TIME_BITS : LONG_W;

  typedef logic [TIME_BITS-1:0] time_t;

  // configuration registers
  logic [DEBOUNCE_W-1:0] debounce_time_r;
  logic [LONG_W-1:0]     long_press_time_r;

  // input stage
  logic  s1_valid_r;
  logic  s1_kind_r;
  time_t s1_now_r;
  logic  s1_raw_r;

  // button state
  logic  last_raw_r,     last_raw_nxt;
  logic  stable_level_r, stable_level_nxt;
  logic  long_done_r,    long_done_nxt;
  time_t change_time_r,  change_time_nxt;
  time_t press_time_r,   press_time_nxt;

  // result register
  logic      out_valid_r;
  press_ev_t out_ev_r, ev_nxt;

  logic     advance;
  logic [CW-1:0] now_ext;
  time_t    el_change;
  time_t    el_press;
  time_t    el_press_new;

  // pipeline handshake
  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2){1'b0}}, out_ev_r};

  // time from the port, zero-extended to CW; cut to TIME_BITS in the input register
  assign now_ext = CW'(in_tdata[NOW_W-1:0]);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_time_r   <= DEBOUNCE_RST;
      long_press_time_r <= LONG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE_TIME:   debounce_time_r   <= cfg_data[DEBOUNCE_W-1:0];
        REG_LONG_PRESS_TIME: long_press_time_r <= cfg_data[LONG_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_kind_r <= in_tuser;
      s1_now_r  <= now_ext[TIME_BITS-1:0];
      s1_raw_r  <= in_tdata[NOW_W];
    end
  end

  // debounce and press detection for the item in the input register
  always_comb begin
    last_raw_nxt     = last_raw_r;
    stable_level_nxt = stable_level_r;
    long_done_nxt    = long_done_r;
    change_time_nxt  = change_time_r;
    press_time_nxt   = press_time_r;
    ev_nxt           = EV_NONE;
    el_change        = '0;
    el_press         = s1_now_r - press_time_r;
    el_press_new     = el_press;

    if (s1_kind_r == KIND_RESYNC) begin
      last_raw_nxt     = s1_raw_r;
      stable_level_nxt = s1_raw_r;
      long_done_nxt    = 1'b0;
      change_time_nxt  = s1_now_r;
      press_time_nxt   = s1_now_r;
    end else begin
      // track raw level changes
      last_raw_nxt = s1_raw_r;
      if (s1_raw_r != last_raw_r) begin
        change_time_nxt = s1_now_r;
      end
      el_change = s1_now_r - change_time_nxt;

      if (CW'(el_change) >= CW'(debounce_time_r)) begin
        // level has settled: update stable level
        if (s1_raw_r != stable_level_r) begin
          stable_level_nxt = s1_raw_r;
          if (s1_raw_r) begin
            press_time_nxt = s1_now_r;
            long_done_nxt  = 1'b0;
            el_press_new   = '0;
          end else if (!long_done_r && (CW'(el_press) < CW'(long_press_time_r))) begin
            ev_nxt = EV_SHORT;
          end
        end
        // long press fires once per hold
        if ((ev_nxt == EV_NONE) && stable_level_nxt && !long_done_nxt &&
            (CW'(el_press_new) >= CW'(long_press_time_r))) begin
          long_done_nxt = 1'b1;
          ev_nxt        = EV_LONG;
        end
      end
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r     <= 1'b0;
      stable_level_r <= 1'b0;
      long_done_r    <= 1'b0;
      change_time_r  <= '0;
      press_time_r   <= '0;
    end else if (advance) begin
      last_raw_r     <= last_raw_nxt;
      stable_level_r <= stable_level_nxt;
      long_done_r    <= long_done_nxt;
      change_time_r  <= change_time_nxt;
      press_time_r   <= press_time_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ev_r <= ev_nxt;
    end
  end

`ifndef SYNTHESIS
  // a long press result leaves the hold marked as reported
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (ev_nxt == EV_LONG)) |=> (long_done_r && stable_level_r))
    else $error("long press not recorded");

  // a resync aligns stable and raw levels and clears the long press mark
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (s1_kind_r == KIND_RESYNC)) |=>
      (!long_done_r && (stable_level_r == last_raw_r) && (out_ev_r == EV_NONE)))
    else $error("resync state mismatch");

  // a short press is only reported on a release
  assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (ev_nxt == EV_SHORT)) |=> !stable_level_r)
    else $error("short press without release");

  // with the result register empty the block always takes input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while output empty");
`endif

endmodule

`default_nettype wire
